// ----- design/ttd_pkg.sv -----
// Shared types and constants for the trace text decoder.
package ttd_pkg;

	localparam int unsigned CharW  = 8;
	localparam int unsigned DigitW = 6;
	localparam int unsigned SumW   = 18;
	localparam int unsigned ValueW = 19;

	localparam logic [CharW-1:0] ChDash  = 8'h2D;
	localparam logic [CharW-1:0] ChDot   = 8'h2E;
	localparam logic [CharW-1:0] ChColon = 8'h3A;
	localparam logic [CharW-1:0] ChZero  = 8'h30;
	localparam logic [CharW-1:0] ChNine  = 8'h39;
	localparam logic [CharW-1:0] ChUpA   = 8'h41;
	localparam logic [CharW-1:0] ChUpZ   = 8'h5A;
	localparam logic [CharW-1:0] ChLoA   = 8'h61;
	localparam logic [CharW-1:0] ChLoZ   = 8'h7A;

	localparam logic [1:0] NeedIdle  = 2'd0;
	localparam logic [1:0] NeedShort = 2'd2;
	localparam logic [1:0] NeedLong  = 2'd3;

	localparam logic [SumW-1:0] Weight1 = 18'd63;
	localparam logic [SumW-1:0] Weight2 = 18'd3969;

	typedef struct packed {
		logic [1:0]      digits_needed;
		logic [1:0]      digit_position;
		logic [SumW-1:0] partial_sum;
	} ttd_state_t;

	typedef struct packed {
		logic              known;
		logic              prefix;
		logic              long_rec;
		logic [DigitW-1:0] digit;
	} ttd_sym_t;

	typedef struct packed {
		logic                     emit;
		logic signed [ValueW-1:0] value;
		logic                     error;
		logic                     last;
	} ttd_result_t;

endpackage

// ----- design/ttd_symbol.sv -----
// Alphabet range decoder: byte to digit value and prefix flags.
module ttd_symbol (
	input  logic [7:0]        char_code,
	output ttd_pkg::ttd_sym_t sym
);
	import ttd_pkg::*;

	always_comb begin
		sym = '0;
		if (char_code == ChDash) begin
			sym.known = 1'b1;
		end else if (char_code >= ChZero && char_code <= ChNine) begin
			sym.known = 1'b1;
			sym.digit = DigitW'(char_code - ChZero + 8'd1);
		end else if (char_code >= ChUpA && char_code <= ChUpZ) begin
			sym.known = 1'b1;
			sym.digit = DigitW'(char_code - ChUpA + 8'd11);
		end else if (char_code >= ChLoA && char_code <= ChLoZ) begin
			sym.known = 1'b1;
			sym.digit = DigitW'(char_code - ChLoA + 8'd37);
		end
		sym.prefix   = (char_code == ChDot) || (char_code == ChColon);
		sym.long_rec = (char_code == ChColon);
	end

endmodule

// ----- design/ttd_record.sv -----
// Record step: next state and optional result for one decoded symbol.
module ttd_record (
	input  ttd_pkg::ttd_state_t  cur,
	input  ttd_pkg::ttd_sym_t    sym,
	input  logic                 eot,
	output ttd_pkg::ttd_state_t  nxt,
	output ttd_pkg::ttd_result_t res
);
	import ttd_pkg::*;

	logic [SumW-1:0] weighted;
	logic [SumW-1:0] new_sum;
	logic [1:0]      new_pos;
	logic [SumW-1:0] digit_ext;

	assign digit_ext = SumW'(sym.digit);

	always_comb begin
		case (cur.digit_position)
			2'd0:    weighted = digit_ext;
			2'd1:    weighted = SumW'(digit_ext * Weight1);
			default: weighted = SumW'(digit_ext * Weight2);
		endcase
	end

	assign new_sum = cur.partial_sum + weighted;
	assign new_pos = cur.digit_position + 2'd1;

	always_comb begin
		nxt       = '0;
		res       = '0;
		res.last  = eot;
		if (cur.digits_needed == NeedIdle) begin
			if (sym.prefix) begin
				if (eot) begin
					res.emit  = 1'b1;
					res.error = 1'b1;
				end else begin
					nxt.digits_needed = sym.long_rec ? NeedLong : NeedShort;
				end
			end else if (!sym.known) begin
				res.emit  = 1'b1;
				res.error = 1'b1;
			end else begin
				res.emit  = 1'b1;
				res.value = ValueW'({1'b0, digit_ext}) - ValueW'(1);
			end
		end else if (!sym.known) begin
			res.emit  = 1'b1;
			res.error = 1'b1;
		end else if (new_pos >= cur.digits_needed) begin
			res.emit  = 1'b1;
			res.value = ValueW'({1'b0, new_sum}) - ValueW'(1);
		end else if (eot) begin
			res.emit  = 1'b1;
			res.error = 1'b1;
		end else begin
			nxt.digits_needed  = cur.digits_needed;
			nxt.digit_position = new_pos;
			nxt.partial_sum    = new_sum;
		end
	end

endmodule

// ----- design/trace_text_decoder_unit.sv -----
// Top level of the trace text decoder: byte stream in, decoded integers out.
//
// Slave stream: one text byte per word in s_axis_tdata[7:0], s_axis_tlast
// marks the final byte of the text. Master stream: one decoded integer per
// word, value in m_axis_tdata[18:0] (two's complement, record value minus
// one), m_axis_tuser flags a bad byte or a text that ended mid record (value
// is then 0), m_axis_tlast copies the final-byte mark of the causing byte.
// Prefix bytes and inner digits of a record produce no output word unless the text ends on them.
// A byte is held in the input register, and its result word is then shown
// in the output register. Throughput is one byte per cycle while the
// receiver does not stall; the decode of a byte is a single pass through
// the symbol decoder and the record step between those two registers.
// When the receiver stalls with a word held, the input register keeps its
// byte and s_axis_tready drops once it is full; a byte that gives no word
// still moves on while the output holds.
// Reset clears both valid flags and returns the decoder to idle.
module trace_text_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [18:0] value, [23:19] zero
	output logic        m_axis_tuser,   // [0] error
	output logic        m_axis_tlast
);
	import ttd_pkg::*;

	logic        valid_s1;
	logic [7:0]  char_s1;
	logic        eot_s1;
	ttd_state_t  state_q;
	ttd_state_t  state_nxt;
	ttd_sym_t    sym;
	ttd_result_t res;
	logic        out_free;
	logic        fire;
	logic signed [ValueW-1:0] value_q;
	logic        error_q;
	logic        last_q;
	logic        out_valid_q;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign fire          = valid_s1 && (out_free || !res.emit);
	assign s_axis_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			char_s1 <= s_axis_tdata;
			eot_s1  <= s_axis_tlast;
		end
	end

	ttd_symbol u_symbol (
		.char_code (char_s1),
		.sym       (sym)
	);

	ttd_record u_record (
		.cur (state_q),
		.sym (sym),
		.eot (eot_s1),
		.nxt (state_nxt),
		.res (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (fire) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && res.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res.emit) begin
			value_q <= res.value;
			error_q <= res.error;
			last_q  <= res.last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'd0, value_q};
	assign m_axis_tuser  = error_q;
	assign m_axis_tlast  = last_q;

`ifndef SYNTHESIS
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 24'd0)
		else $error("error word carries a nonzero value");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.digits_needed == NeedIdle |->
			state_q.digit_position == 2'd0 && state_q.partial_sum == '0)
		else $error("idle decoder holds stale record state");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.digits_needed != NeedIdle |->
			(state_q.digits_needed == NeedShort || state_q.digits_needed == NeedLong)
			&& state_q.digit_position < state_q.digits_needed)
		else $error("record position out of range");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fire && eot_s1 |=> state_q.digits_needed == NeedIdle)
		else $error("decoder not idle after final byte");
`endif

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// Testbench for trace_text_decoder_unit: directed and random text checked against a decode predictor.
module tb;
	import ttd_pkg::*;

	localparam int QuietTail = 150;
	localparam int HoldCycles = 250;

	typedef struct packed {
		logic [CharW-1:0] ch;
		logic             eot;
	} text_byte_t;

	typedef struct packed {
		logic signed [ValueW-1:0] value;
		logic                     error;
		logic                     last;
	} int_word_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_valid = 1'b0;
	logic              s_ready;
	logic [CharW-1:0]  s_data = '0;
	logic              s_last = 1'b0;
	logic              m_valid;
	logic              m_ready = 1'b0;
	logic [23:0]       m_data;
	logic              m_user;
	logic              m_last;

	text_byte_t text_q[$];
	int_word_t  value_q[$];
	int         errors = 0;
	int         taken = 0;
	logic       hold_off = 1'b0;
	int         tx_gap, rx_gap;
	logic       tx_calm = 1'b0;
	logic       rx_calm = 1'b0;
	text_byte_t tx_byte;
	int_word_t  tx_word, rx_word;

	// decoder state mirror
	logic [1:0]      need_st = NeedIdle;
	logic [1:0]      pos_st = 2'd0;
	logic [SumW-1:0] sum_st = '0;

	trace_text_decoder_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_valid),
		.s_axis_tready (s_ready),
		.s_axis_tdata  (s_data),
		.s_axis_tlast  (s_last),
		.m_axis_tvalid (m_valid),
		.m_axis_tready (m_ready),
		.m_axis_tdata  (m_data),
		.m_axis_tuser  (m_user),
		.m_axis_tlast  (m_last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic bit symbol_digit(input logic [CharW-1:0] ch, output logic [DigitW-1:0] d);
		d = '0;
		if (ch == ChDash)
			return 1'b1;
		if (ch >= ChZero && ch <= ChNine) begin
			d = DigitW'(ch - ChZero + 8'd1);
			return 1'b1;
		end
		if (ch >= ChUpA && ch <= ChUpZ) begin
			d = DigitW'(ch - ChUpA + 8'd11);
			return 1'b1;
		end
		if (ch >= ChLoA && ch <= ChLoZ) begin
			d = DigitW'(ch - ChLoA + 8'd37);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic logic [CharW-1:0] digit_char(input int d);
		if (d == 0)
			return ChDash;
		if (d <= 10)
			return ChZero + CharW'(d - 1);
		if (d <= 36)
			return ChUpA + CharW'(d - 11);
		return ChLoA + CharW'(d - 37);
	endfunction

	function automatic void go_idle();
		need_st = NeedIdle;
		pos_st = 2'd0;
		sum_st = '0;
	endfunction

	// advances the mirror by one text byte; returns 1 when a word is due
	function automatic bit decode_byte(input logic [CharW-1:0] ch, input logic eot,
			output int_word_t w);
		logic [DigitW-1:0] d;
		logic              known;
		logic [SumW-1:0]   weight;
		known = symbol_digit(ch, d);
		w.value = '0;
		w.error = 1'b1;
		w.last = eot;
		if (need_st == NeedIdle) begin
			if (ch == ChColon || ch == ChDot) begin
				if (eot)
					return 1'b1;
				need_st = (ch == ChColon) ? NeedLong : NeedShort;
				pos_st = 2'd0;
				sum_st = '0;
				return 1'b0;
			end
			if (known) begin
				w.error = 1'b0;
				w.value = ValueW'(d) - 19'd1;
			end
			return 1'b1;
		end
		if (!known) begin
			go_idle();
			return 1'b1;
		end
		weight = (pos_st == 2'd0) ? 18'd1 : (pos_st == 2'd1) ? Weight1 : Weight2;
		sum_st = sum_st + SumW'(d) * weight;
		pos_st = pos_st + 2'd1;
		if (pos_st >= need_st) begin
			w.error = 1'b0;
			w.value = {1'b0, sum_st} - 19'd1;
			go_idle();
			return 1'b1;
		end
		if (eot) begin
			go_idle();
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic report_mismatch(input string what, input logic [23:0] got,
			input logic [23:0] want);
		$display("%0t: %s mismatch: got %0h, expected %0h", $realtime, what, got, want);
		errors++;
	endtask

	task automatic push_text(input logic [CharW-1:0] ch, input logic eot);
		text_byte_t b;
		b.ch = ch;
		b.eot = eot;
		text_q = {text_q, b};
	endtask

	function automatic int rand_digit();
		int r;
		r = $urandom_range(0, 7);
		if (r == 0)
			return 0;
		if (r == 1)
			return 62;
		return $urandom_range(0, 62);
	endfunction

	function automatic logic [CharW-1:0] rand_bad_char();
		logic [CharW-1:0] ch;
		logic [DigitW-1:0] d;
		do
			ch = CharW'($urandom_range(0, 255));
		while (symbol_digit(ch, d));
		return ch;
	endfunction

	task automatic push_record(input int len, input logic eot);
		if (len == 2)
			push_text(ChDot, 1'b0);
		else if (len == 3)
			push_text(ChColon, 1'b0);
		for (int i = 0; i < len; i++)
			push_text(digit_char(rand_digit()), (i == len - 1) ? eot : 1'b0);
	endtask

	task automatic push_broken();
		int len, got;
		len = $urandom_range(2, 3);
		got = $urandom_range(0, len - 1);
		if ($urandom_range(0, 1)) begin
			push_text((len == 3) ? ChColon : ChDot, got == 0);
			for (int i = 0; i < got; i++)
				push_text(digit_char(rand_digit()), i == got - 1);
		end else begin
			push_text((len == 3) ? ChColon : ChDot, 1'b0);
			for (int i = 0; i < got; i++)
				push_text(digit_char(rand_digit()), 1'b0);
			push_text(rand_bad_char(), $urandom_range(0, 7) == 0);
		end
	endtask

	task automatic build_text();
		int r;
		// plain symbols at the alphabet edges
		push_text(ChDash, 1'b0);
		push_text(ChZero, 1'b0);
		push_text(ChNine, 1'b1);
		push_text(ChUpA, 1'b0);
		push_text(ChUpZ, 1'b0);
		push_text(ChLoA, 1'b0);
		push_text(ChLoZ, 1'b0);
		// unknown bytes while idle
		push_text(8'h00, 1'b0);
		push_text(8'hFF, 1'b1);
		// largest short and long records, smallest long record
		push_text(ChDot, 1'b0);
		push_text(ChLoZ, 1'b0);
		push_text(ChLoZ, 1'b0);
		push_text(ChColon, 1'b0);
		push_text(ChDash, 1'b0);
		push_text(ChDash, 1'b0);
		push_text(ChDash, 1'b0);
		push_text(ChColon, 1'b0);
		push_text(ChLoZ, 1'b0);
		push_text(ChLoZ, 1'b0);
		push_text(ChLoZ, 1'b1);
		// prefix inside a record
		push_text(ChDot, 1'b0);
		push_text(ChDot, 1'b0);
		// text ends mid record, on a digit and on a prefix
		push_text(ChColon, 1'b0);
		push_text(ChUpA, 1'b1);
		push_text(ChDot, 1'b1);

		while (text_q.size() < 1550) begin
			r = $urandom_range(0, 99);
			if (r < 35)
				push_record(1, $urandom_range(0, 15) == 0);
			else if (r < 60)
				push_record(2, $urandom_range(0, 15) == 0);
			else if (r < 85)
				push_record(3, $urandom_range(0, 15) == 0);
			else if (r < 93)
				push_text(CharW'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
			else
				push_broken();
		end
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_valid <= 1'b0;
			s_data <= '0;
			s_last <= 1'b0;
			tx_gap <= 0;
		end else begin
			if (s_valid && s_ready) begin
				if (decode_byte(s_data, s_last, tx_word))
					value_q = {value_q, tx_word};
				taken++;
			end
			if ($urandom_range(0, 63) == 0)
				tx_calm <= !tx_calm;
			if (!s_valid || s_ready) begin
				if (tx_gap > 0) begin
					tx_gap <= tx_gap - 1;
					s_valid <= 1'b0;
				end else if (text_q.size() > QuietTail && !tx_calm && $urandom_range(0, 7) == 0) begin
					tx_gap <= $urandom_range(0, 6);
					s_valid <= 1'b0;
				end else if (text_q.size() != 0) begin
					tx_byte = text_q.pop_front();
					s_valid <= 1'b1;
					s_data <= tx_byte.ch;
					s_last <= tx_byte.eot;
				end else begin
					s_valid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_ready <= 1'b0;
			rx_gap <= 0;
		end else begin
			if (m_valid && m_ready) begin
				if (value_q.size() == 0) begin
					report_mismatch("unexpected word", m_data, '0);
				end else begin
					rx_word = value_q.pop_front();
					if (m_data !== {5'd0, rx_word.value})
						report_mismatch("value", m_data, {5'd0, rx_word.value});
					if (m_user !== rx_word.error)
						report_mismatch("error", 24'(m_user), 24'(rx_word.error));
					if (m_last !== rx_word.last)
						report_mismatch("last", 24'(m_last), 24'(rx_word.last));
				end
			end
			if ($urandom_range(0, 63) == 0)
				rx_calm <= !rx_calm;
			if (rx_gap > 0) begin
				rx_gap <= rx_gap - 1;
				m_ready <= 1'b0;
			end else if (text_q.size() > QuietTail && !rx_calm && $urandom_range(0, 7) == 0) begin
				rx_gap <= $urandom_range(0, 6);
				m_ready <= 1'b0;
			end else begin
				m_ready <= !hold_off;
			end
		end
	end

	// long receiver stall so the input side backs up
	initial begin
		while (taken < 300)
			@(negedge clk);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HoldCycles) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		#2ms;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		build_text();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		while (text_q.size() != 0 || s_valid)
			@(negedge clk);
		while (value_q.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
design/ttd_pkg.sv
design/ttd_symbol.sv
design/ttd_record.sv
design/trace_text_decoder_unit.sv
test/tb.sv
